/* rtl/lir_pkg.sv */
// Shared types and constants of the linear interpolation resampler.
// Holds the payload structs, the controller command and status bundles and the register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int RATE_BITS    = 18;
  localparam int RESULT_CAP   = 32;
  localparam int CNT_BITS     = $clog2(RESULT_CAP + 1);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IN_RATE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_RATE = CFG_IDX_BITS'(1);

  localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(48000);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          sample_valid;
    logic                          last_result;
    logic                          ratio_error;
  } out_item_t;

  typedef enum logic [1:0] {
    PEND_CUR,
    PEND_INTERP,
    PEND_REFUSED
  } pend_src_e;

  typedef struct packed {
    logic      load_item;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      diff_load;
    logic      mul_start;
    logic      div_start;
    logic      set_prev;
    logic      phase_zero;
    logic      phase_wrap;
    logic      phase_step;
    logic      clr_stream;
    logic      pend_load;
    logic      pend_push;
    logic      flush;
    pend_src_e pend_src;
  } ctrl_cmd_t;

  typedef struct packed {
    logic refused;
    logic equal;
    logic have_prev;
    logic eos;
    logic phase_lt_out;
    logic cap_hit;
    logic div_done;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/lir_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// The caller guarantees that the quotient fits in QUO_W bits.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lir_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 19,
  parameter int QUO_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quot_o
);

  localparam int HI_W  = NUM_W - QUO_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] low_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [HI_W-1:0]  num_hi;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  assign num_hi    = num_i[NUM_W-1:QUO_W];
  assign trial     = {rem_q, low_q[QUO_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_hi[DEN_W-1:0];
      low_q <= num_i[QUO_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      low_q <= {low_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule

`default_nettype wire

/* rtl/lir_datapath.sv */
// Datapath of the resampler: stream state, phase accumulator, multiplier, divider,
// pending result and output register. Driven by commands from lir_ctrl.
// Depends on lir_pkg and lir_div.
`timescale 1ns / 1ps
`default_nettype none

module lir_datapath import lir_pkg::*; #(
  parameter int MAX_RATIO = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ctrl_cmd_t      cmd_i,
  output dp_status_t          status_o,
  input  wire in_item_t       in_item_i,
  input  wire logic [RATE_BITS-1:0] in_rate_i,
  input  wire logic [RATE_BITS-1:0] out_rate_i,
  input  wire logic           out_stall_i,
  output logic                out_valid_o,
  output out_item_t           out_item_o
);

  localparam int SB     = SAMPLE_BITS;
  localparam int PH_W   = RATE_BITS + 1;
  localparam int PROD_W = SB + RATE_BITS;
  localparam int NUM_W  = PROD_W + 2;
  localparam int LIM_W  = RATE_BITS + $clog2(MAX_RATIO + 1);

  logic signed [SB-1:0] cur_q;
  logic                 eos_q;
  logic signed [SB-1:0] prev_q;
  logic                 have_q;
  logic [PH_W-1:0]      phase_q;
  logic [PH_W-1:0]      phase_d;
  logic [CNT_BITS-1:0]  cnt_q;
  logic [SB-1:0]        diff_mag_q;
  logic                 neg_q;
  logic [PROD_W-1:0]    prod_q;
  out_item_t            pend_q;
  logic                 pend_valid_q;
  out_item_t            out_q;
  logic                 out_valid_q;

  logic [SB:0]          diff_w;
  logic [SB:0]          diff_abs;
  logic [NUM_W-1:0]     div_num;
  logic [PH_W-1:0]      div_den;
  logic                 div_done;
  logic [SB-1:0]        quot;
  logic signed [SB:0]   interp_sum;
  logic [LIM_W-1:0]     rate_lim;
  logic                 out_free;
  out_item_t            pend_new;
  out_item_t            flush_item;

  assign diff_w   = {cur_q[SB-1], cur_q} - {prev_q[SB-1], prev_q};
  assign diff_abs = diff_w[SB] ? ('0 - diff_w) : diff_w;

  assign div_num = NUM_W'({prod_q, 1'b0}) + NUM_W'(out_rate_i);
  assign div_den = {out_rate_i, 1'b0};

  lir_div #(
    .NUM_W(NUM_W),
    .DEN_W(PH_W),
    .QUO_W(SB)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign interp_sum = neg_q ? ({prev_q[SB-1], prev_q} - {1'b0, quot})
                            : ({prev_q[SB-1], prev_q} + {1'b0, quot});

  assign rate_lim = LIM_W'(in_rate_i) * LIM_W'(MAX_RATIO);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.pend_src)
      PEND_CUR: begin
        pend_new = '{sample_out: cur_q, sample_valid: 1'b1, last_result: 1'b0,
                     ratio_error: 1'b0};
      end
      PEND_INTERP: begin
        pend_new = '{sample_out: interp_sum[SB-1:0], sample_valid: 1'b1,
                     last_result: 1'b0, ratio_error: 1'b0};
      end
      PEND_REFUSED: begin
        pend_new = '{sample_out: '0, sample_valid: 1'b0, last_result: 1'b0,
                     ratio_error: 1'b1};
      end
      default: begin
        pend_new = '{sample_out: cur_q, sample_valid: 1'b1, last_result: 1'b0,
                     ratio_error: 1'b0};
      end
    endcase
  end

  always_comb begin
    if (pend_valid_q) begin
      flush_item             = pend_q;
      flush_item.last_result = eos_q;
    end else begin
      flush_item = '{sample_out: '0, sample_valid: 1'b0, last_result: 1'b1,
                     ratio_error: 1'b0};
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (cmd_i.clr_stream || cmd_i.phase_zero) begin
      phase_d = '0;
    end else if (cmd_i.phase_wrap) begin
      phase_d = (phase_q >= PH_W'(out_rate_i)) ? (phase_q - PH_W'(out_rate_i)) : '0;
    end else if (cmd_i.phase_step) begin
      phase_d = phase_q + PH_W'(in_rate_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      have_q       <= 1'b0;
      phase_q      <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (cmd_i.clr_stream) begin
        prev_q <= '0;
        have_q <= 1'b0;
      end else if (cmd_i.set_prev) begin
        prev_q <= cur_q;
        have_q <= 1'b1;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.pend_load) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.pend_push || cmd_i.flush) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cur_q <= in_item_i.sample_in;
      eos_q <= in_item_i.end_of_stream;
    end
    if (cmd_i.diff_load) begin
      diff_mag_q <= diff_abs[SB-1:0];
      neg_q      <= diff_w[SB];
    end
    if (cmd_i.mul_start) begin
      prod_q <= PROD_W'(diff_mag_q) * PROD_W'(phase_q[RATE_BITS-1:0]);
    end
    if (cmd_i.pend_load) begin
      pend_q <= pend_new;
    end
    if (cmd_i.pend_push) begin
      out_q <= pend_q;
    end else if (cmd_i.flush) begin
      out_q <= flush_item;
    end
  end

  assign status_o.refused      = (in_rate_i == '0) || (out_rate_i == '0) ||
                                 (LIM_W'(out_rate_i) > rate_lim);
  assign status_o.equal        = in_rate_i == out_rate_i;
  assign status_o.have_prev    = have_q;
  assign status_o.eos          = eos_q;
  assign status_o.phase_lt_out = phase_q < PH_W'(out_rate_i);
  assign status_o.cap_hit      = cnt_q == CNT_BITS'(RESULT_CAP);
  assign status_o.div_done     = div_done;
  assign status_o.pend_valid   = pend_valid_q;
  assign status_o.out_free     = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pend_push || cmd_i.flush) && out_valid_q |-> !out_stall_i)
    else $error("result pushed over a stalled output register");

  a_pend_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pend_load && pend_valid_q |-> cmd_i.pend_push)
    else $error("pending result overwritten before it was sent");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(RESULT_CAP))
    else $error("result count beyond the cap");

  a_quot_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> quot <= diff_mag_q)
    else $error("interpolation step larger than the sample difference");
`endif

endmodule

`default_nettype wire

/* rtl/lir_ctrl.sv */
// Controller state machine of the resampler: sequences each request through the
// rate checks, the interpolation loop, the end-of-stream hold loop and the final flush.
// Depends on lir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lir_ctrl import lir_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LOOP1 = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;
  localparam logic [2:0] S_LOOP2 = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       room;

  assign room = !status_i.pend_valid || status_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          state_d         = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.refused) begin
          cmd_o.pend_load = 1'b1;
          cmd_o.pend_src  = PEND_REFUSED;
          state_d         = S_FLUSH;
        end else if (status_i.equal) begin
          cmd_o.pend_load  = 1'b1;
          cmd_o.pend_src   = PEND_CUR;
          cmd_o.set_prev   = 1'b1;
          cmd_o.phase_zero = 1'b1;
          state_d          = S_FLUSH;
        end else if (status_i.have_prev) begin
          cmd_o.diff_load = 1'b1;
          state_d         = S_LOOP1;
        end else begin
          cmd_o.set_prev   = 1'b1;
          cmd_o.phase_zero = 1'b1;
          state_d          = status_i.eos ? S_LOOP2 : S_IDLE;
        end
      end
      S_LOOP1: begin
        if (status_i.phase_lt_out && !status_i.cap_hit) begin
          cmd_o.mul_start = 1'b1;
          state_d         = S_MUL;
        end else begin
          cmd_o.phase_wrap = 1'b1;
          cmd_o.set_prev   = 1'b1;
          state_d          = status_i.eos ? S_LOOP2 : S_FLUSH;
        end
      end
      S_MUL: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (room) begin
          cmd_o.pend_load  = 1'b1;
          cmd_o.pend_src   = PEND_INTERP;
          cmd_o.pend_push  = status_i.pend_valid;
          cmd_o.phase_step = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          state_d          = S_LOOP1;
        end
      end
      S_LOOP2: begin
        if (status_i.phase_lt_out && !status_i.cap_hit) begin
          if (room) begin
            cmd_o.pend_load  = 1'b1;
            cmd_o.pend_src   = PEND_CUR;
            cmd_o.pend_push  = status_i.pend_valid;
            cmd_o.phase_step = 1'b1;
            cmd_o.cnt_inc    = 1'b1;
          end
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (status_i.pend_valid || status_i.eos) begin
          if (status_i.out_free) begin
            cmd_o.flush      = 1'b1;
            cmd_o.clr_stream = status_i.eos;
            state_d          = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

`default_nettype wire

/* rtl/linear_interp_resampler.sv */
// Linear interpolation sample-rate converter: top level with the rate registers.
// A request is passed through or refused, or only stores a first sample that is not last, or else
// yields interpolated results (16-step serial divider) and, at end of stream, held results.
// One request is worked on at a time; the next is taken once the last result is in the output register.
// Reset is asynchronous, active low: it clears the stream state and sets both rates to 48000.
// Depends on lir_pkg, lir_ctrl and lir_datapath.
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler import lir_pkg::*; #(
  parameter int MAX_RATIO = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire in_item_t                in_item_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output out_item_t                    out_item_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [RATE_BITS-1:0]    cfg_data_i
);

  logic [RATE_BITS-1:0] in_rate_q;
  logic [RATE_BITS-1:0] out_rate_q;
  ctrl_cmd_t            cmd;
  dp_status_t           status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rate_q  <= RATE_RESET;
      out_rate_q <= RATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IN_RATE: begin
          in_rate_q <= cfg_data_i;
        end
        CFG_OUT_RATE: begin
          out_rate_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  lir_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lir_datapath #(
    .MAX_RATIO(MAX_RATIO)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_item_i  (in_item_i),
    .in_rate_i  (in_rate_q),
    .out_rate_i (out_rate_q),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
